[src/pfpc_pkg.sv]
package pfpc_pkg;

  localparam int StackDepth = 32;
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int IdxW       = $clog2(StackDepth);
  localparam int CodeW      = 3;
  localparam int SymW       = 8;
  localparam int ErrW       = 2;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [SymW-1:0]  sym_t;
  typedef logic [ErrW-1:0]  err_t;

  localparam code_t CODE_PLUS   = 3'd0;
  localparam code_t CODE_MINUS  = 3'd1;
  localparam code_t CODE_STAR   = 3'd2;
  localparam code_t CODE_SLASH  = 3'd3;
  localparam code_t CODE_MARKER = 3'd4;

  localparam sym_t CHAR_PLUS  = 8'h2B;
  localparam sym_t CHAR_MINUS = 8'h2D;
  localparam sym_t CHAR_STAR  = 8'h2A;
  localparam sym_t CHAR_SLASH = 8'h2F;
  localparam sym_t CHAR_NUL   = 8'h00;

  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNDERFLOW = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN_RD  = 8'b0000_0010,
    ST_SCAN_CHK = 8'b0000_0100,
    ST_EMIT_OPD = 8'b0000_1000,
    ST_EMIT_RD  = 8'b0001_0000,
    ST_EMIT_OP  = 8'b0010_0000,
    ST_PUSH     = 8'b0100_0000,
    ST_OVF      = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic scan_pop;
    logic emit_rd;
    logic load_opd;
    logic load_op;
    logic load_ovf;
    logic push_marker;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic acc_full;
    logic cnt_zero;
    logic cnt_one;
    logic top_marker;
    logic last_pending;
    logic out_free;
  } sts_t;

  function automatic logic is_operator(sym_t s);
    return (s == CHAR_PLUS) || (s == CHAR_MINUS) || (s == CHAR_STAR) || (s == CHAR_SLASH);
  endfunction

  function automatic code_t op_code(sym_t s);
    code_t c;
    case (s)
      CHAR_MINUS: c = CODE_MINUS;
      CHAR_STAR:  c = CODE_STAR;
      CHAR_SLASH: c = CODE_SLASH;
      default:    c = CODE_PLUS;
    endcase
    return c;
  endfunction

  function automatic sym_t code_to_char(logic [1:0] c);
    sym_t s;
    case (c)
      2'd1:    s = CHAR_MINUS;
      2'd2:    s = CHAR_STAR;
      2'd3:    s = CHAR_SLASH;
      default: s = CHAR_PLUS;
    endcase
    return s;
  endfunction

endpackage

[src/pfpc_in_if.sv]
interface pfpc_in_if;
  logic                valid;
  logic                ready;
  logic [pfpc_pkg::SymW-1:0] in_symbol;
  logic                first_of_expression;

  modport source (output valid, output in_symbol, output first_of_expression, input ready);
  modport sink   (input valid, input in_symbol, input first_of_expression, output ready);
endinterface

[src/pfpc_out_if.sv]
interface pfpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [pfpc_pkg::SymW-1:0] out_symbol;
  logic                      last_in_run;
  logic [pfpc_pkg::ErrW-1:0] error_code;
  logic                      expression_done;

  modport source (output valid, output out_symbol, output last_in_run, output error_code,
                  output expression_done, input ready);
  modport sink   (input valid, input out_symbol, input last_in_run, input error_code,
                  input expression_done, output ready);
endinterface

[src/pfpc_ram.sv]
module pfpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pfpc_ctrl.sv]
module pfpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pfpc_pkg::sts_t  sts,
  output pfpc_pkg::cmd_t  cmd
);

  pfpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == pfpc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      pfpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.is_op) begin
            state_nxt = pfpc_pkg::ST_SCAN_RD;
          end else if (sts.acc_full) begin
            state_nxt = pfpc_pkg::ST_OVF;
          end
        end
      end
      pfpc_pkg::ST_SCAN_RD: begin
        if (sts.cnt_zero) begin
          state_nxt = pfpc_pkg::ST_EMIT_OPD;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = pfpc_pkg::ST_SCAN_CHK;
        end
      end
      pfpc_pkg::ST_SCAN_CHK: begin
        // pop marker and operator beneath; a lone marker ends the scan
        if (sts.top_marker) begin
          cmd.scan_pop = 1'b1;
          state_nxt    = sts.cnt_one ? pfpc_pkg::ST_EMIT_OPD : pfpc_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = pfpc_pkg::ST_EMIT_OPD;
        end
      end
      pfpc_pkg::ST_EMIT_OPD: begin
        if (sts.out_free) begin
          cmd.load_opd = 1'b1;
          state_nxt    = sts.last_pending ? pfpc_pkg::ST_PUSH : pfpc_pkg::ST_EMIT_RD;
        end
      end
      pfpc_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = pfpc_pkg::ST_EMIT_OP;
      end
      pfpc_pkg::ST_EMIT_OP: begin
        if (sts.out_free) begin
          cmd.load_op = 1'b1;
          state_nxt   = sts.last_pending ? pfpc_pkg::ST_PUSH : pfpc_pkg::ST_EMIT_RD;
        end
      end
      pfpc_pkg::ST_PUSH: begin
        cmd.push_marker = 1'b1;
        state_nxt       = pfpc_pkg::ST_IDLE;
      end
      pfpc_pkg::ST_OVF: begin
        if (sts.out_free) begin
          cmd.load_ovf = 1'b1;
          state_nxt    = pfpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/pfpc_dpath.sv]
module pfpc_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pfpc_pkg::SymW-1:0] in_symbol,
  input  logic                      first_of_expression,
  input  pfpc_pkg::cmd_t            cmd,
  output pfpc_pkg::sts_t            sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [pfpc_pkg::SymW-1:0] out_symbol,
  output logic                      last_in_run,
  output logic [pfpc_pkg::ErrW-1:0] error_code,
  output logic                      expression_done
);

  localparam logic [pfpc_pkg::CntW-1:0] DepthCnt = pfpc_pkg::CntW'(pfpc_pkg::StackDepth);
  localparam logic [pfpc_pkg::CntW-1:0] OneCnt   = pfpc_pkg::CntW'(1);
  localparam logic [pfpc_pkg::CntW-1:0] TwoCnt   = pfpc_pkg::CntW'(2);

  pfpc_pkg::sym_t              sym_r;
  logic [pfpc_pkg::CntW-1:0]   cnt_r;
  logic [pfpc_pkg::CntW-1:0]   emit_r;
  logic                        unf_r;
  logic                        out_valid_r;
  pfpc_pkg::sym_t              out_sym_r;
  logic                        out_last_r;
  pfpc_pkg::err_t              out_err_r;
  logic                        out_done_r;

  logic [pfpc_pkg::CntW-1:0]   acc_cnt;
  logic [pfpc_pkg::CntW-1:0]   cnt_m1;
  logic [pfpc_pkg::CntW-1:0]   emit_m2;
  logic [pfpc_pkg::CntW-1:0]   remain;
  logic                        is_op;
  pfpc_pkg::err_t              err_final;
  pfpc_pkg::err_t              err_cur;

  logic                        ram_we;
  logic [pfpc_pkg::IdxW-1:0]   ram_waddr;
  pfpc_pkg::code_t             ram_wdata;
  logic                        ram_re;
  logic [pfpc_pkg::IdxW-1:0]   ram_raddr;
  pfpc_pkg::code_t             ram_rdata;

  assign is_op   = pfpc_pkg::is_operator(in_symbol);
  assign acc_cnt = first_of_expression ? '0 : cnt_r;
  assign cnt_m1  = cnt_r - OneCnt;
  assign emit_m2 = emit_r - TwoCnt;
  // operators still to emit sit at every other slot between emit_r and cnt_r
  assign remain  = emit_r - cnt_r;

  assign err_final = unf_r ? pfpc_pkg::ERR_UNDERFLOW
                   : ((cnt_r == DepthCnt) ? pfpc_pkg::ERR_OVERFLOW : pfpc_pkg::ERR_NONE);
  assign err_cur   = sts.last_pending ? err_final : pfpc_pkg::ERR_NONE;

  always_comb begin
    sts              = '0;
    sts.is_op        = is_op;
    sts.acc_full     = (acc_cnt == DepthCnt);
    sts.cnt_zero     = (cnt_r == '0);
    sts.cnt_one      = (cnt_r == OneCnt);
    sts.top_marker   = (ram_rdata == pfpc_pkg::CODE_MARKER);
    sts.last_pending = (remain < TwoCnt);
    sts.out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_cnt[pfpc_pkg::IdxW-1:0];
    ram_wdata = pfpc_pkg::op_code(in_symbol);
    if (cmd.accept && is_op && (acc_cnt != DepthCnt)) begin
      ram_we = 1'b1;
    end else if (cmd.push_marker && (cnt_r != DepthCnt)) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[pfpc_pkg::IdxW-1:0];
      ram_wdata = pfpc_pkg::CODE_MARKER;
    end
  end

  assign ram_re    = cmd.scan_rd || cmd.emit_rd;
  assign ram_raddr = cmd.emit_rd ? emit_m2[pfpc_pkg::IdxW-1:0] : cnt_m1[pfpc_pkg::IdxW-1:0];

  pfpc_ram #(
    .Width (pfpc_pkg::CodeW),
    .Depth (pfpc_pkg::StackDepth)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cnt_r <= (is_op && (acc_cnt != DepthCnt)) ? acc_cnt + OneCnt : acc_cnt;
      end else if (cmd.scan_pop) begin
        cnt_r <= (cnt_r == OneCnt) ? '0 : cnt_r - TwoCnt;
      end else if (cmd.push_marker && (cnt_r != DepthCnt)) begin
        cnt_r <= cnt_r + OneCnt;
      end
      if (cmd.load_opd || cmd.load_op || cmd.load_ovf) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r  <= in_symbol;
      emit_r <= acc_cnt;
      unf_r  <= 1'b0;
    end else begin
      if (cmd.scan_pop && (cnt_r == OneCnt)) begin
        unf_r <= 1'b1;
      end
      if (cmd.emit_rd) begin
        emit_r <= emit_m2;
      end
    end
    if (cmd.load_opd) begin
      out_sym_r  <= sym_r;
      out_last_r <= sts.last_pending;
      out_err_r  <= err_cur;
      out_done_r <= (cnt_r == '0);
    end else if (cmd.load_op) begin
      out_sym_r  <= pfpc_pkg::code_to_char(ram_rdata[1:0]);
      out_last_r <= sts.last_pending;
      out_err_r  <= err_cur;
      out_done_r <= (cnt_r == '0);
    end else if (cmd.load_ovf) begin
      out_sym_r  <= pfpc_pkg::CHAR_NUL;
      out_last_r <= 1'b1;
      out_err_r  <= pfpc_pkg::ERR_OVERFLOW;
      out_done_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_sym_r;
  assign last_in_run     = out_last_r;
  assign error_code      = out_err_r;
  assign expression_done = out_done_r;

endmodule

[src/prefix_to_postfix_converter_top.sv]
// Operator item: taken with no result; ready again the next cycle
// (overflowing operator: one result, loaded once the output is free).
// Operand item popping p operator pairs: each pop reads the stack top, then the operand
// and each popped operator are emitted, waiting on any output stalls; the stack RAM's
// single registered read port serves each pop and each emit. Then the marker is pushed.
// One item at a time; the last result may wait in the output register while the next is
// taken. Reset clears the controller, stack count and output valid; stack RAM is kept.
module prefix_to_postfix_converter_top (
  input logic        clk,
  input logic        rst_n,
  pfpc_in_if.sink    in_ch,
  pfpc_out_if.source out_ch
);

  pfpc_pkg::cmd_t cmd;
  pfpc_pkg::sts_t sts;

  pfpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfpc_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_symbol           (in_ch.in_symbol),
    .first_of_expression (in_ch.first_of_expression),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_symbol          (out_ch.out_symbol),
    .last_in_run         (out_ch.last_in_run),
    .error_code          (out_ch.error_code),
    .expression_done     (out_ch.expression_done)
  );

endmodule

[bench/prefix_to_postfix_converter_top_tb.sv]
module prefix_to_postfix_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    pfpc_pkg::sym_t sym;
    logic           last;
    pfpc_pkg::err_t err;
    logic           done;
  } postfix_char_t;

  logic clk = 1'b0;
  logic rst_n;

  pfpc_in_if  in_ch ();
  pfpc_out_if out_ch ();

  prefix_to_postfix_converter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Own copy of the pending operator/marker stack
  pfpc_pkg::code_t op_stack [pfpc_pkg::StackDepth];
  int              op_count = 0;
  postfix_char_t   postfix_q [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int gap_max      = 0;
  int ready_pct    = 100;
  int hold_request = 0;

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic pfpc_pkg::sym_t op_symbol(input int idx);
    pfpc_pkg::sym_t s;
    case (idx % 4)
      0:       s = pfpc_pkg::CHAR_PLUS;
      1:       s = pfpc_pkg::CHAR_MINUS;
      2:       s = pfpc_pkg::CHAR_STAR;
      default: s = pfpc_pkg::CHAR_SLASH;
    endcase
    return s;
  endfunction

  function automatic pfpc_pkg::sym_t rand_operator();
    return op_symbol($urandom_range(0, 3));
  endfunction

  function automatic pfpc_pkg::sym_t rand_operand();
    pfpc_pkg::sym_t s;
    do s = pfpc_pkg::sym_t'($urandom_range(0, 255));
    while (s == pfpc_pkg::CHAR_PLUS || s == pfpc_pkg::CHAR_MINUS ||
           s == pfpc_pkg::CHAR_STAR || s == pfpc_pkg::CHAR_SLASH);
    return s;
  endfunction

  // Work out the postfix characters one accepted item gives and queue them
  task automatic convert_symbol(input pfpc_pkg::sym_t s, input logic first);
    pfpc_pkg::sym_t  syms [$];
    postfix_char_t   r;
    pfpc_pkg::err_t  err;
    logic            done;
    logic            is_op;
    pfpc_pkg::code_t c;
    err = pfpc_pkg::ERR_NONE;
    is_op = 1'b1;
    c = pfpc_pkg::CODE_PLUS;
    case (s)
      pfpc_pkg::CHAR_PLUS:  c = pfpc_pkg::CODE_PLUS;
      pfpc_pkg::CHAR_MINUS: c = pfpc_pkg::CODE_MINUS;
      pfpc_pkg::CHAR_STAR:  c = pfpc_pkg::CODE_STAR;
      pfpc_pkg::CHAR_SLASH: c = pfpc_pkg::CODE_SLASH;
      default:              is_op = 1'b0;
    endcase
    if (first) op_count = 0;
    if (is_op) begin
      if (op_count < pfpc_pkg::StackDepth) begin
        op_stack[op_count] = c;
        op_count++;
      end else begin
        syms.push_back(pfpc_pkg::CHAR_NUL);
        err = pfpc_pkg::ERR_OVERFLOW;
      end
    end else begin
      syms.push_back(s);
      // unwind every completed operator
      while (op_count > 0 && op_stack[op_count-1] == pfpc_pkg::CODE_MARKER) begin
        op_count--;
        if (op_count == 0) begin
          err = pfpc_pkg::ERR_UNDERFLOW;
          break;
        end
        op_count--;
        syms.push_back(op_symbol(int'(op_stack[op_count][1:0])));
      end
      if (op_count < pfpc_pkg::StackDepth) begin
        op_stack[op_count] = pfpc_pkg::CODE_MARKER;
        op_count++;
      end else begin
        err = pfpc_pkg::ERR_OVERFLOW;
      end
    end
    done = (op_count == 1) && (op_stack[0] == pfpc_pkg::CODE_MARKER);
    foreach (syms[i]) begin
      r.sym  = syms[i];
      r.last = (i == syms.size() - 1);
      r.err  = r.last ? err : pfpc_pkg::ERR_NONE;
      r.done = done;
      postfix_q.push_back(r);
    end
  endtask

  // Entered and left at a falling edge
  task automatic send_item(input pfpc_pkg::sym_t s, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid               <= 1'b1;
    in_ch.in_symbol           <= s;
    in_ch.first_of_expression <= first;
    do @(posedge clk);
    while (in_ch.ready !== 1'b1);
    burst_left--;
    items_sent++;
    convert_symbol(s, first);
    @(negedge clk);
  endtask

  task automatic send_string(input string str, input logic first_on_head);
    for (int i = 0; i < str.len(); i++)
      send_item(pfpc_pkg::sym_t'(str[i]), first_on_head && i == 0);
  endtask

  // Random well-formed prefix expression; cut > 0 breaks it off after that many items
  task automatic send_expression(input int max_ops, input logic first, input int cut);
    int need;
    int ops;
    int n;
    need = 1;
    ops = 0;
    n = 0;
    while (need > 0 && (cut == 0 || n < cut)) begin
      if (ops < max_ops && $urandom_range(0, 1) == 1) begin
        send_item(rand_operator(), first && n == 0);
        need++;
        ops++;
      end else begin
        send_item(rand_operand(), first && n == 0);
        need--;
      end
      n++;
    end
  endtask

  task automatic test_basic_conversion();
    gap_max = 2;
    ready_pct = 70;
    send_string("+ab", 1'b1);
    send_item(pfpc_pkg::CHAR_MINUS, 1'b1);
    send_item(pfpc_pkg::CHAR_STAR, 1'b0);
    send_item(pfpc_pkg::CHAR_SLASH, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_string("cd", 1'b0);
    send_string("x", 1'b1);
    // operand with nothing pending beneath the marker
    send_string("y", 1'b0);
    // restart in the middle of an expression
    send_string("*q", 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_stack_limits();
    gap_max = 3;
    ready_pct = 50;
    // fill with operator/marker pairs, then unwind them all with one operand
    for (int i = 0; i < pfpc_pkg::StackDepth / 2; i++) begin
      send_item(op_symbol(i), i == 0);
      send_item(rand_operand(), 1'b0);
    end
    send_item(rand_operand(), 1'b0);
    for (int i = 0; i < pfpc_pkg::StackDepth; i++) send_item(op_symbol(i), i == 0);
    send_item(pfpc_pkg::CHAR_STAR, 1'b0);
    send_item(rand_operand(), 1'b0);
  endtask

  task automatic test_random_expressions();
    int start;
    int kind;
    start = items_sent;
    while (items_sent - start < 20) begin
      kind = $urandom_range(0, 9);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(30, 90);
      if (kind < 6) begin
        send_expression($urandom_range(1, 8), 1'b1, 0);
      end else if (kind == 6) begin
        send_expression($urandom_range(2, 8), 1'b1, $urandom_range(1, 6));
      end else if (kind == 7) begin
        // carry on from whatever the stack holds
        send_expression($urandom_range(0, 6), 1'b0, 0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(pfpc_pkg::sym_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    ready_pct = 100;
    hold_request = 300;
    // several operands while the receiver holds off: the input must stall
    send_string("*+ab-cd", 1'b1);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk) begin : check_output
    postfix_char_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (postfix_q.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %02h", out_ch.out_symbol));
      end else begin
        want = postfix_q.pop_front();
        if (out_ch.out_symbol !== want.sym || out_ch.last_in_run !== want.last ||
            out_ch.error_code !== want.err || out_ch.expression_done !== want.done)
          report_mismatch($sformatf(
            "sym/last/err/done got %02h/%b/%0d/%b want %02h/%b/%0d/%b",
            out_ch.out_symbol, out_ch.last_in_run, out_ch.error_code,
            out_ch.expression_done, want.sym, want.last, want.err, want.done));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_symbol = '0;
    in_ch.first_of_expression = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_basic_conversion();
    test_stack_limits();
    test_random_expressions();
    test_backpressure();
    in_ch.valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
